// ----- design/edfrq_pkg.sv -----
// ----------------------------------------------------------------------------
// edfrq_pkg: shared types and constants of the EDF ready queue
// Sizes, field widths, status and operation codes, and the structs that pass
// between the top level, the task map and the sorted cell chain.
// ----------------------------------------------------------------------------
package edfrq_pkg;

   localparam int MAX_TASKS   = 64;
   localparam int QUEUE_DEPTH = 16;

   localparam int REQ_TYPE_W  = 2;
   localparam int TASK_ID_W   = 6;
   localparam int REL_DL_W    = 32;
   localparam int DEADLINE_W  = 64;
   localparam int STATUS_W    = 2;
   localparam int TOTAL_W     = 5;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // request types
   localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ENQUEUE  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DEQUEUE  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED   = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNREG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STATE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // internal operation after checks
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_REG  = 2'd1;
   localparam logic [1:0] OP_ENQ  = 2'd2;
   localparam logic [1:0] OP_DEQ  = 2'd3;

   // contents of one cell of the sorted chain
   typedef struct packed {
      logic                  valid;
      logic [TASK_ID_W-1:0]  task_id;
      logic [DEADLINE_W-1:0] deadline;
   } cell_data_type;

   // broadcast command to every cell
   typedef struct packed {
      logic                  en;
      logic                  enq;
      logic                  deq;
      logic [TASK_ID_W-1:0]  task_id;
      logic [DEADLINE_W-1:0] deadline;
   } cell_cmd_type;

   // update of the per-id bitmaps
   typedef struct packed {
      logic                 en;
      logic [1:0]           op;
      logic [TASK_ID_W-1:0] task_id;
      logic                 exiting;
   } map_cmd_type;

   // per-id flags looked up for the request being accepted
   typedef struct packed {
      logic registered;
      logic queued;
   } map_flags_type;

endpackage

// ----- design/edf_ready_queue.sv -----
// ----------------------------------------------------------------------------
// edf_ready_queue: earliest-deadline-first ready queue of task ids
// Registers, enqueues and dequeues tasks; queued tasks sit in a chain of
// cells sorted by absolute deadline, earliest in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transfer carries a request type, a task id,
//   a relative deadline, the current time and an exiting flag.
//   Response channel (rsp_*): exactly one transfer per request, in order,
//   with a status and the queue state after the request: earliest task, its
//   deadline and the number of queued tasks.
//   A request is checked against the task flags and its deadline formed
//   before it is taken into the execute stage; the cell chain and the flags
//   update when the execute stage fires, when the response register is
//   loaded, which waits while a stalled response still holds the output
//   register. A new request is taken only once the execute stage has
//   emptied, as the check stage and the chain update stage hold one
//   request at a time.
//   A stalled response is held in its output register; a further request is
//   still taken and waits in the execute stage until the response leaves,
//   with req_stall high meanwhile.
//   Reset (synchronous): empties the queue, clears all task flags and drops
//   any request or response in flight. No clearing pass is needed.
// ----------------------------------------------------------------------------
module edf_ready_queue (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [edfrq_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [edfrq_pkg::TASK_ID_W-1:0]      req_task_id,
   input  logic [edfrq_pkg::REL_DL_W-1:0]       req_rel_deadline,
   input  logic [edfrq_pkg::DEADLINE_W-1:0]     req_now,
   input  logic                                 req_task_exiting,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [edfrq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                 rsp_earliest_valid,
   output logic [edfrq_pkg::TASK_ID_W-1:0]      rsp_earliest_id,
   output logic [edfrq_pkg::DEADLINE_W-1:0]     rsp_earliest_deadline,
   output logic [edfrq_pkg::TOTAL_W-1:0]        rsp_queued_total
);
   import edfrq_pkg::*;

   // ---------------- check stage ----------------
   logic                  req_fire;
   map_flags_type         flags;
   logic                  id_known;
   logic [DEADLINE_W:0]   dl_sum;
   logic [DEADLINE_W-1:0] dl_sat;
   logic [1:0]            op_chk;
   logic [STATUS_W-1:0]   status_chk;

   // ---------------- execute stage ----------------
   logic                  exec_valid_ff;
   logic                  exec_valid_in;
   logic [1:0]            exec_op_ff;
   logic [STATUS_W-1:0]   exec_status_ff;
   logic [TASK_ID_W-1:0]  exec_id_ff;
   logic [DEADLINE_W-1:0] exec_deadline_ff;
   logic                  exec_exiting_ff;
   logic                  exec_fire;

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;

   cell_cmd_type          cell_cmd;
   map_cmd_type           map_cmd;

   // ---------------- response register ----------------
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_earliest_valid_ff;
   logic [TASK_ID_W-1:0]  rsp_earliest_id_ff;
   logic [DEADLINE_W-1:0] rsp_earliest_deadline_ff;
   logic [TOTAL_W-1:0]    rsp_queued_total_ff;

   // ---------------- cell chain wiring ----------------
   cell_data_type         cell_cur   [QUEUE_DEPTH];
   cell_data_type         head_next;
   logic                  cell_stay  [QUEUE_DEPTH];
   logic                  cell_found [QUEUE_DEPTH];

   // A new request waits only while the execute stage is occupied.
   assign req_stall = exec_valid_ff;
   assign req_fire  = req_valid && !req_stall;

   edfrq_task_map u_task_map (
      .clock        (clock),
      .reset        (reset),
      .lookup_id    (req_task_id),
      .lookup_flags (flags),
      .cmd          (map_cmd)
   );

   assign id_known = (32'(req_task_id) < 32'(MAX_TASKS));

   // Absolute deadline, saturating at the all-ones value on carry out.
   assign dl_sum = {1'b0, req_now} + (DEADLINE_W + 1)'(req_rel_deadline);
   assign dl_sat = dl_sum[DEADLINE_W] ? '1 : dl_sum[DEADLINE_W-1:0];

   // Decide status and the operation to perform; failures perform nothing.
   always_comb begin
      op_chk     = OP_NONE;
      status_chk = ST_OK;
      if (!id_known && (req_type != REQ_UNUSED)) begin
         status_chk = ST_UNREG;
      end else begin
         unique case (req_type)
            REQ_REGISTER: op_chk = OP_REG;
            REQ_ENQUEUE: begin
               priority if (!flags.registered) begin
                  status_chk = ST_UNREG;
               end else if (flags.queued) begin
                  status_chk = ST_STATE;
               end else if (count_ff >= COUNT_W'(QUEUE_DEPTH)) begin
                  status_chk = ST_FULL;
               end else begin
                  op_chk = OP_ENQ;
               end
            end
            REQ_DEQUEUE: begin
               priority if (!flags.registered) begin
                  status_chk = ST_UNREG;
               end else if (!flags.queued) begin
                  status_chk = ST_STATE;
               end else begin
                  op_chk = OP_DEQ;
               end
            end
            REQ_UNUSED: op_chk = OP_NONE;
            default:    op_chk = OP_NONE;
         endcase
      end
   end

   // Execute only when the response register is free or being emptied.
   assign exec_fire = exec_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (req_fire) begin
         exec_valid_in = 1'b1;
      end else if (exec_fire) begin
         exec_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
      end
   end

   // Hold the checked request for the execute cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         exec_op_ff       <= op_chk;
         exec_status_ff   <= status_chk;
         exec_id_ff       <= req_task_id;
         exec_deadline_ff <= dl_sat;
         exec_exiting_ff  <= req_task_exiting;
      end
   end

   // Broadcast the operation to all cells and to the flag map.
   assign cell_cmd = '{en:       exec_fire,
                       enq:      (exec_op_ff == OP_ENQ),
                       deq:      (exec_op_ff == OP_DEQ),
                       task_id:  exec_id_ff,
                       deadline: exec_deadline_ff};

   assign map_cmd = '{en:      exec_fire,
                      op:      exec_op_ff,
                      task_id: exec_id_ff,
                      exiting: exec_exiting_ff};

   // Sorted chain: each cell sees its neighbours and passes the dequeue
   // match on to the right, so the matching cell and every cell after it advance.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_data_type left_d;
      logic          left_s;
      cell_data_type right_d;
      logic          found_i;

      if (i == 0) begin : g_head
         assign left_d  = '{valid: 1'b1, task_id: '0, deadline: '0};
         assign left_s  = 1'b1;
         assign found_i = 1'b0;
      end else begin : g_body
         assign left_d  = cell_cur[i-1];
         assign left_s  = cell_stay[i-1];
         assign found_i = cell_found[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_d = '{valid: 1'b0, task_id: '0, deadline: '0};
      end else begin : g_inner
         assign right_d = cell_cur[i+1];
      end

      edfrq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .left_data  (left_d),
         .left_stay  (left_s),
         .right_data (right_d),
         .found_in   (found_i),
         .cur_out    (cell_cur[i]),
         .stay_out   (cell_stay[i]),
         .found_out  (cell_found[i])
      );

      // Contents the head cell will hold after this execute cycle.
      if (i == 0) begin : g_head_next
         always_comb begin
            head_next = cell_cur[i];
            if (cell_cmd.enq && !cell_stay[i]) begin
               head_next = '{valid: 1'b1, task_id: exec_id_ff,
                             deadline: exec_deadline_ff};
            end else if (cell_cmd.deq && cell_found[i]) begin
               head_next = right_d;
            end
         end
      end
   end

   // Queued count: advance on enqueue, drop on dequeue.
   always_comb begin
      count_in = count_ff;
      if (exec_fire) begin
         unique case (exec_op_ff)
            OP_ENQ:  count_in = count_ff + COUNT_W'(1);
            OP_DEQ:  count_in = count_ff - COUNT_W'(1);
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register: load on execute, drop once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An empty queue reports zero for the earliest task and deadline.
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff         <= exec_status_ff;
         rsp_earliest_valid_ff <= (count_in != '0);
         rsp_earliest_id_ff    <= (count_in != '0) ? head_next.task_id : '0;
         rsp_earliest_deadline_ff <= (count_in != '0) ? head_next.deadline : '0;
         rsp_queued_total_ff   <= TOTAL_W'(count_in);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_earliest_valid    = rsp_earliest_valid_ff;
   assign rsp_earliest_id       = rsp_earliest_id_ff;
   assign rsp_earliest_deadline = rsp_earliest_deadline_ff;
   assign rsp_queued_total      = rsp_queued_total_ff;

endmodule

// ----- design/edfrq_cell.sv -----
// ----------------------------------------------------------------------------
// edfrq_cell: one slot of the deadline-sorted chain
// Holds one queued task; on enqueue it keeps, takes the new task or takes its
// left neighbour; on dequeue it takes its right neighbour at or behind the match.
// ----------------------------------------------------------------------------
module edfrq_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  edfrq_pkg::cell_cmd_type  cmd,
   input  edfrq_pkg::cell_data_type left_data,
   input  logic                     left_stay,
   input  edfrq_pkg::cell_data_type right_data,
   input  logic                     found_in,
   output edfrq_pkg::cell_data_type cur_out,
   output logic                     stay_out,
   output logic                     found_out
);
   import edfrq_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [TASK_ID_W-1:0]  task_ff;
   logic [DEADLINE_W-1:0] deadline_ff;
   cell_data_type         data_in;
   logic                  match;

   assign cur_out = '{valid: valid_ff, task_id: task_ff, deadline: deadline_ff};

   // equal deadlines stay ahead of the new entry
   assign stay_out  = valid_ff && (deadline_ff <= cmd.deadline);
   assign match     = valid_ff && (task_ff == cmd.task_id);
   assign found_out = found_in || match;

   always_comb begin
      data_in = cur_out;
      if (cmd.enq) begin
         if (!left_stay && left_data.valid) begin
            data_in = left_data;
         end else if (!stay_out && left_stay) begin
            data_in = '{valid: 1'b1, task_id: cmd.task_id, deadline: cmd.deadline};
         end
      end else if (cmd.deq && found_out) begin
         data_in = right_data;
      end
   end

   assign valid_in = data_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         task_ff     <= data_in.task_id;
         deadline_ff <= data_in.deadline;
      end
   end

endmodule

// ----- design/edfrq_task_map.sv -----
// ----------------------------------------------------------------------------
// edfrq_task_map: per-id registered and queued flags
// Looks up both flags for the arriving request and applies the update of the
// request being executed.
// ----------------------------------------------------------------------------
module edfrq_task_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [edfrq_pkg::TASK_ID_W-1:0]    lookup_id,
   output edfrq_pkg::map_flags_type           lookup_flags,
   input  edfrq_pkg::map_cmd_type             cmd
);
   import edfrq_pkg::*;

   logic [MAX_TASKS-1:0] registered_ff;
   logic [MAX_TASKS-1:0] registered_in;
   logic [MAX_TASKS-1:0] queued_ff;
   logic [MAX_TASKS-1:0] queued_in;

   assign lookup_flags = '{registered: registered_ff[lookup_id],
                           queued:     queued_ff[lookup_id]};

   always_comb begin
      registered_in = registered_ff;
      queued_in     = queued_ff;
      if (cmd.en) begin
         unique case (cmd.op)
            OP_REG: registered_in[cmd.task_id] = 1'b1;
            OP_ENQ: queued_in[cmd.task_id]     = 1'b1;
            OP_DEQ: begin
               queued_in[cmd.task_id] = 1'b0;
               if (cmd.exiting) begin
                  registered_in[cmd.task_id] = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         queued_ff     <= '0;
      end else begin
         registered_ff <= registered_in;
         queued_ff     <= queued_in;
      end
   end

endmodule
